/* sv/lmts_pkg.sv */
// Shared types, constants and helpers for the LCD mode timing sequencer.
// No dependencies; imported by the top level and by its checker.
`timescale 1ns / 1ps

package lmts_pkg;

   // Display modes as the status register reports them.
   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_COMPARE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STAT_ENABLES = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HBLANK_CYC   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OAM_CYC      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_XFER_CYC     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_CYC     = 3'd5;

   // Bits of the stat interrupt enable register.
   localparam int STAT_EN_HBLANK = 0;
   localparam int STAT_EN_VBLANK = 1;
   localparam int STAT_EN_OAM    = 2;
   localparam int STAT_EN_LYC    = 3;

   // Default frame geometry.
   localparam int DEF_VISIBLE_LINES = 144;
   localparam int DEF_TOTAL_LINES   = 154;

   // Register values after reset.
   localparam logic [9:0]  RST_HBLANK_CYC = 10'd204;
   localparam logic [9:0]  RST_OAM_CYC    = 10'd80;
   localparam logic [9:0]  RST_XFER_CYC   = 10'd172;
   localparam logic [10:0] RST_LINE_CYC   = 11'd456;

   // Clamp an 18-bit signed intermediate to the 16-bit signed counter range.
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

/* sv/lcd_mode_timing_sequencer.sv */
// Top level of the LCD mode timing sequencer: mode, scanline and interrupt timing.
// Depends on lmts_pkg for mode codes, register indexes and the saturating helper.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  elapsed (8), display_on (1)
// rsp_      out        rsp_valid/rsp_stall  cur_mode, cur_line, coincident, irq pulses
// csr_      in         csr_valid/csr_ready  index (3), wdata (11)
//
// Every item is held in the input register, then passes through the step logic into
// the result register. A new item is taken every cycle unless the result stalls; the
// step logic updates the timing state in the same cycle it loads the result, so one
// item follows another directly.
// Reset loads the default register values and clears mode, line and coincidence.
// A stalled result holds both stages; the input side stalls only when both are full.

module lcd_mode_timing_sequencer #(
   parameter int VISIBLE_LINES = lmts_pkg::DEF_VISIBLE_LINES,
   parameter int TOTAL_LINES   = lmts_pkg::DEF_TOTAL_LINES
) (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_elapsed,
   input  logic                               req_display_on,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_cur_mode,
   output logic [7:0]                         rsp_cur_line,
   output logic                               rsp_coincident,
   output logic                               rsp_vblank_irq,
   output logic                               rsp_stat_irq,
   output logic                               rsp_render_line,
   // configuration channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lmts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lmts_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import lmts_pkg::*;

   localparam logic [7:0] VisLine   = 8'(VISIBLE_LINES);
   localparam logic [7:0] TotalLine = 8'(TOTAL_LINES);

   // Configuration registers
   logic [7:0]  line_compare_ff;
   logic [3:0]  stat_en_ff;
   logic [9:0]  hblank_cyc_ff;
   logic [9:0]  oam_cyc_ff;
   logic [9:0]  xfer_cyc_ff;
   logic [10:0] line_cyc_ff;

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  elapsed_ff;
   logic        display_on_ff;

   // Timing state
   mode_type           mode_ff, mode_in;
   logic [7:0]         line_ff, line_in;
   logic               coincide_ff, coincide_in;
   logic signed [15:0] hblank_left_ff, hblank_left_in;
   logic signed [15:0] oam_left_ff, oam_left_in;
   logic signed [15:0] xfer_left_ff, xfer_left_in;
   logic signed [15:0] line_left_ff, line_left_in;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_mode_ff;
   logic [7:0]  out_line_ff;
   logic        out_coincide_ff;
   logic        out_vblank_ff, vblank_in;
   logic        out_stat_ff, stat_in;
   logic        out_render_ff, render_in;

   // Pipeline control
   logic out_free;
   logic step_go;
   logic req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_go   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (step_go) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // One timing step: mode phase, then line counter, then vblank entry.
   always_comb begin
      logic signed [17:0] e_s;
      logic               hb_exit;
      mode_type           start_mode;
      logic [7:0]         line_inc;

      e_s        = $signed({10'd0, elapsed_ff});
      start_mode = mode_ff;
      hb_exit    = 1'b0;
      line_inc   = line_ff + 8'd1;

      mode_in        = mode_ff;
      line_in        = line_ff;
      coincide_in    = coincide_ff;
      hblank_left_in = hblank_left_ff;
      oam_left_in    = oam_left_ff;
      xfer_left_in   = xfer_left_ff;
      line_left_in   = line_left_ff;
      vblank_in      = 1'b0;
      stat_in        = 1'b0;
      render_in      = 1'b0;

      if (!display_on_ff) begin
         // Display off reloads all counters and clears position.
         hblank_left_in = $signed({6'd0, hblank_cyc_ff});
         oam_left_in    = $signed({6'd0, oam_cyc_ff});
         xfer_left_in   = $signed({6'd0, xfer_cyc_ff});
         line_left_in   = $signed({5'd0, line_cyc_ff});
         line_in        = 8'd0;
         mode_in        = MODE_HBLANK;
         coincide_in    = 1'b0;
      end else begin
         // Mode phase: count down, carry the overshoot into the next phase.
         unique case (start_mode)
            MODE_OAM: begin
               oam_left_in = sat16(18'(oam_left_ff) - e_s);
               if (oam_left_in <= 16'sd0) begin
                  xfer_left_in = sat16(18'(xfer_left_ff) + 18'(oam_left_in));
                  oam_left_in  = $signed({6'd0, oam_cyc_ff});
                  mode_in      = MODE_XFER;
               end
            end
            MODE_XFER: begin
               xfer_left_in = sat16(18'(xfer_left_ff) - e_s);
               if (xfer_left_in <= 16'sd0) begin
                  hblank_left_in = sat16(18'(hblank_left_ff) + 18'(xfer_left_in));
                  xfer_left_in   = $signed({6'd0, xfer_cyc_ff});
                  mode_in        = MODE_HBLANK;
                  render_in      = (line_ff < VisLine);
                  stat_in        = stat_en_ff[STAT_EN_HBLANK];
               end
            end
            MODE_HBLANK: begin
               hblank_left_in = sat16(18'(hblank_left_ff) - e_s);
               hb_exit        = (hblank_left_in <= 16'sd0) && (line_ff < VisLine);
               if (hb_exit) begin
                  oam_left_in    = sat16(18'(oam_left_ff) + 18'(hblank_left_in));
                  hblank_left_in = $signed({6'd0, hblank_cyc_ff});
                  mode_in        = MODE_OAM;
                  stat_in        = stat_en_ff[STAT_EN_OAM];
               end
            end
            MODE_VBLANK: begin
               if (line_ff == 8'd0) begin
                  mode_in = MODE_OAM;
                  stat_in = stat_en_ff[STAT_EN_OAM];
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase

         // Line counter: compare uses the line before the increment.
         line_left_in = sat16(18'(line_left_ff) - e_s);
         if (line_left_in <= 16'sd0) begin
            line_left_in = sat16(18'(line_left_in) + $signed({7'd0, line_cyc_ff}));
            coincide_in  = (line_compare_ff == line_ff);
            if (coincide_in && stat_en_ff[STAT_EN_LYC]) begin
               stat_in = 1'b1;
            end
            line_in = (line_inc == TotalLine) ? 8'd0 : line_inc;
         end

         // Entering vertical blank.
         if (line_in == VisLine && start_mode != MODE_VBLANK) begin
            hblank_left_in = $signed({6'd0, hblank_cyc_ff});
            mode_in        = MODE_VBLANK;
            vblank_in      = 1'b1;
            if (stat_en_ff[STAT_EN_VBLANK]) begin
               stat_in = 1'b1;
            end
         end
      end
   end

   // Registers: configuration, input stage, timing state and result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_compare_ff <= 8'd0;
         stat_en_ff      <= 4'd0;
         hblank_cyc_ff   <= RST_HBLANK_CYC;
         oam_cyc_ff      <= RST_OAM_CYC;
         xfer_cyc_ff     <= RST_XFER_CYC;
         line_cyc_ff     <= RST_LINE_CYC;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         mode_ff         <= MODE_HBLANK;
         line_ff         <= 8'd0;
         coincide_ff     <= 1'b0;
         hblank_left_ff  <= $signed({6'd0, RST_HBLANK_CYC});
         oam_left_ff     <= $signed({6'd0, RST_OAM_CYC});
         xfer_left_ff    <= $signed({6'd0, RST_XFER_CYC});
         line_left_ff    <= $signed({5'd0, RST_LINE_CYC});
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LINE_COMPARE: line_compare_ff <= csr_wdata[7:0];
               CSR_STAT_ENABLES: stat_en_ff      <= csr_wdata[3:0];
               CSR_HBLANK_CYC:   hblank_cyc_ff   <= csr_wdata[9:0];
               CSR_OAM_CYC:      oam_cyc_ff      <= csr_wdata[9:0];
               CSR_XFER_CYC:     xfer_cyc_ff     <= csr_wdata[9:0];
               CSR_LINE_CYC:     line_cyc_ff     <= csr_wdata[10:0];
               default: begin
               end
            endcase
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // Payload of the input stage; only its valid bit is reset.
         if (req_take) begin
            elapsed_ff    <= req_elapsed;
            display_on_ff <= req_display_on;
         end
         if (step_go) begin
            mode_ff         <= mode_in;
            line_ff         <= line_in;
            coincide_ff     <= coincide_in;
            hblank_left_ff  <= hblank_left_in;
            oam_left_ff     <= oam_left_in;
            xfer_left_ff    <= xfer_left_in;
            line_left_ff    <= line_left_in;
            out_mode_ff     <= mode_in;
            out_line_ff     <= line_in;
            out_coincide_ff <= coincide_in;
            out_vblank_ff   <= vblank_in;
            out_stat_ff     <= stat_in;
            out_render_ff   <= render_in;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_cur_mode    = out_mode_ff;
   assign rsp_cur_line    = out_line_ff;
   assign rsp_coincident  = out_coincide_ff;
   assign rsp_vblank_irq  = out_vblank_ff;
   assign rsp_stat_irq    = out_stat_ff;
   assign rsp_render_line = out_render_ff;

endmodule

/* sv/lmts_checker.sv */
// Port-level checker for the LCD mode timing sequencer, bound to the top level.
// Depends on lmts_pkg for the mode codes.
`timescale 1ns / 1ps

module lmts_checker #(
   parameter int VISIBLE_LINES = lmts_pkg::DEF_VISIBLE_LINES,
   parameter int TOTAL_LINES   = lmts_pkg::DEF_TOTAL_LINES
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_cur_mode,
   input logic [7:0] rsp_cur_line,
   input logic       rsp_vblank_irq,
   input logic       rsp_render_line
);

   import lmts_pkg::*;

   localparam logic [7:0] VisLine   = 8'(VISIBLE_LINES);
   localparam logic [7:0] TotalLine = 8'(TOTAL_LINES);

   // The scanline always wraps before it reaches the frame length.
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cur_line < TotalLine))
      else $error("scanline beyond frame length");

   // A vblank interrupt comes only with the vblank mode on the first blank line.
   a_vblank_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_vblank_irq) |->
         (rsp_cur_mode == MODE_VBLANK && rsp_cur_line == VisLine))
      else $error("vblank interrupt outside vblank entry");

   // A render pulse marks the end of transfer, so the mode has left it.
   a_render_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_render_line) |->
         (rsp_cur_mode == MODE_HBLANK || rsp_cur_mode == MODE_VBLANK))
      else $error("render pulse while still in search or transfer");

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_cur_line) && $stable(rsp_cur_mode)))
      else $error("stalled result changed");

endmodule

bind lcd_mode_timing_sequencer lmts_checker #(
   .VISIBLE_LINES(VISIBLE_LINES),
   .TOTAL_LINES  (TOTAL_LINES)
) u_lmts_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_cur_mode   (rsp_cur_mode),
   .rsp_cur_line   (rsp_cur_line),
   .rsp_vblank_irq (rsp_vblank_irq),
   .rsp_render_line(rsp_render_line)
);

/* sim/tb_lcd_mode_timing_sequencer.sv */
// Self-checking testbench for the LCD mode timing sequencer: a queue-fed driver, a
// random-stall monitor and a cycle-step predictor of mode, scanline and interrupt pulses.
// Depends on lmts_pkg and the lcd_mode_timing_sequencer top level.
`timescale 1ns / 1ps

module tb_lcd_mode_timing_sequencer;
   import lmts_pkg::*;

   // Frame geometry used by the predictor, matching the instance defaults.
   localparam int VISIBLE = DEF_VISIBLE_LINES;
   localparam int TOTAL   = DEF_TOTAL_LINES;

   // Register indexes that select no register.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam int RANDOM_PHASES   = 10;
   localparam int STEPS_PER_PHASE = 145;

   typedef struct packed {
      logic [7:0] elapsed;
      logic       display_on;
   } timing_step_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] line;
      logic       coincident;
      logic       vblank_irq;
      logic       stat_irq;
      logic       render_line;
   } lcd_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_elapsed    = '0;
   logic                   req_display_on = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [1:0]             rsp_cur_mode;
   logic [7:0]             rsp_cur_line;
   logic                   rsp_coincident;
   logic                   rsp_vblank_irq;
   logic                   rsp_stat_irq;
   logic                   rsp_render_line;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;

   lcd_mode_timing_sequencer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_elapsed     (req_elapsed),
      .req_display_on  (req_display_on),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cur_mode    (rsp_cur_mode),
      .rsp_cur_line    (rsp_cur_line),
      .rsp_coincident  (rsp_coincident),
      .rsp_vblank_irq  (rsp_vblank_irq),
      .rsp_stat_irq    (rsp_stat_irq),
      .rsp_render_line (rsp_render_line),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Clock generation.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   timing_step_type pending_steps[$];
   lcd_status_type  expected_status[$];
   int              errors     = 0;
   bit              quiet      = 1'b0;
   logic            req_taken  = 1'b0;
   int              send_gap   = 0;
   int              stall_left = 0;

   // Predictor copy of the configuration registers.
   logic [7:0] cfg_lyc;
   logic [3:0] cfg_stat_en;
   int         cfg_hblank;
   int         cfg_oam;
   int         cfg_xfer;
   int         cfg_line;

   // Predictor copy of the timing state.
   mode_type   st_mode;
   logic [7:0] st_line;
   logic       st_coinc;
   int         cnt_hblank;
   int         cnt_oam;
   int         cnt_xfer;
   int         cnt_line;

   function automatic int clip16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic void reload_counters();
      cnt_hblank = cfg_hblank;
      cnt_oam    = cfg_oam;
      cnt_xfer   = cfg_xfer;
      cnt_line   = cfg_line;
   endfunction

   function automatic void reset_timing_model();
      cfg_lyc     = '0;
      cfg_stat_en = '0;
      cfg_hblank  = int'(RST_HBLANK_CYC);
      cfg_oam     = int'(RST_OAM_CYC);
      cfg_xfer    = int'(RST_XFER_CYC);
      cfg_line    = int'(RST_LINE_CYC);
      st_mode     = MODE_HBLANK;
      st_line     = '0;
      st_coinc    = 1'b0;
      reload_counters();
   endfunction

   // Register write as the block sees it; unknown indexes change nothing.
   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_LINE_COMPARE: cfg_lyc = data[7:0];
         CSR_STAT_ENABLES: cfg_stat_en = data[3:0];
         CSR_HBLANK_CYC:   cfg_hblank = int'(data[9:0]);
         CSR_OAM_CYC:      cfg_oam = int'(data[9:0]);
         CSR_XFER_CYC:     cfg_xfer = int'(data[9:0]);
         CSR_LINE_CYC:     cfg_line = int'(data[10:0]);
         default: ;
      endcase
   endfunction

   // One timing step: mode walk, line counter, vblank entry and the pulses they raise.
   function automatic lcd_status_type advance_timing(input logic [7:0] elapsed,
                                                     input logic display_on);
      lcd_status_type res;
      mode_type       entry_mode;
      int             e;
      res = '0;
      e = int'(elapsed);
      if (!display_on) begin
         reload_counters();
         st_line  = '0;
         st_mode  = MODE_HBLANK;
         st_coinc = 1'b0;
      end else begin
         entry_mode = st_mode;
         case (entry_mode)
            MODE_OAM: begin
               cnt_oam = clip16(cnt_oam - e);
               if (cnt_oam <= 0) begin
                  cnt_xfer = clip16(cnt_xfer + cnt_oam);
                  cnt_oam  = cfg_oam;
                  st_mode  = MODE_XFER;
               end
            end
            MODE_XFER: begin
               cnt_xfer = clip16(cnt_xfer - e);
               if (cnt_xfer <= 0) begin
                  cnt_hblank = clip16(cnt_hblank + cnt_xfer);
                  cnt_xfer   = cfg_xfer;
                  st_mode    = MODE_HBLANK;
                  if (st_line < VISIBLE) res.render_line = 1'b1;
                  if (cfg_stat_en[STAT_EN_HBLANK]) res.stat_irq = 1'b1;
               end
            end
            MODE_HBLANK: begin
               // Past the visible lines hblank never exits and keeps counting down.
               cnt_hblank = clip16(cnt_hblank - e);
               if (cnt_hblank <= 0 && st_line < VISIBLE) begin
                  cnt_oam    = clip16(cnt_oam + cnt_hblank);
                  cnt_hblank = cfg_hblank;
                  st_mode    = MODE_OAM;
                  if (cfg_stat_en[STAT_EN_OAM]) res.stat_irq = 1'b1;
               end
            end
            default: begin
               if (st_line == 8'd0) begin
                  st_mode = MODE_OAM;
                  if (cfg_stat_en[STAT_EN_OAM]) res.stat_irq = 1'b1;
               end
            end
         endcase

         // The coincidence compare uses the line before the increment.
         cnt_line = clip16(cnt_line - e);
         if (cnt_line <= 0) begin
            cnt_line = clip16(cnt_line + cfg_line);
            if (cfg_lyc == st_line) begin
               st_coinc = 1'b1;
               if (cfg_stat_en[STAT_EN_LYC]) res.stat_irq = 1'b1;
            end else begin
               st_coinc = 1'b0;
            end
            st_line = st_line + 8'd1;
            if (st_line == TOTAL) st_line = '0;
         end

         if (st_line == VISIBLE && entry_mode != MODE_VBLANK) begin
            cnt_hblank     = cfg_hblank;
            st_mode        = MODE_VBLANK;
            res.vblank_irq = 1'b1;
            if (cfg_stat_en[STAT_EN_VBLANK]) res.stat_irq = 1'b1;
         end
      end
      res.mode       = st_mode;
      res.line       = st_line;
      res.coincident = st_coinc;
      return res;
   endfunction

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // Monitor and predictor: results are compared first, then the accepted step is predicted.
   always @(posedge clock) begin
      lcd_status_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               errors++;
               $display({"%0t ns: result transfer with nothing expected, expected none, ",
                         "actual mode %0d line %0d"}, $time, rsp_cur_mode, rsp_cur_line);
            end else begin
               want = expected_status.pop_front();
               check_field("cur_mode", want.mode, rsp_cur_mode);
               check_field("cur_line", want.line, rsp_cur_line);
               check_field("coincident", want.coincident, rsp_coincident);
               check_field("vblank_irq", want.vblank_irq, rsp_vblank_irq);
               check_field("stat_irq", want.stat_irq, rsp_stat_irq);
               check_field("render_line", want.render_line, rsp_render_line);
            end
         end
         if (req_valid && !req_stall) begin
            expected_status.push_back(advance_timing(req_elapsed, req_display_on));
         end
      end
   end

   // Input driver: a new step is offered once the previous transfer has happened.
   always @(negedge clock) begin
      timing_step_type nxt;
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_steps.size() > 0) begin
            nxt = pending_steps.pop_front();
            req_valid      <= 1'b1;
            req_elapsed    <= nxt.elapsed;
            req_display_on <= nxt.display_on;
            if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall in random bursts.
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 10);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic queue_step(input logic [7:0] elapsed, input logic display_on);
      timing_step_type s;
      s.elapsed    = elapsed;
      s.display_on = display_on;
      pending_steps.push_back(s);
   endtask

   function automatic logic [7:0] pick_elapsed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return 8'($urandom_range(0, 7));
      if (r < 25) return 8'd0;
      if (r < 32) return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
   endtask

   // Writes every register, optionally followed by writes to the unused indexes.
   task automatic program_all(input logic [7:0] lyc, input logic [3:0] en,
                              input logic [9:0] hb, input logic [9:0] oam,
                              input logic [9:0] xfer, input logic [10:0] ln,
                              input bit spares);
      write_csr(CSR_LINE_COMPARE, CSR_DATA_W'(lyc));
      write_csr(CSR_STAT_ENABLES, CSR_DATA_W'(en));
      write_csr(CSR_HBLANK_CYC, CSR_DATA_W'(hb));
      write_csr(CSR_OAM_CYC, CSR_DATA_W'(oam));
      write_csr(CSR_XFER_CYC, CSR_DATA_W'(xfer));
      write_csr(CSR_LINE_CYC, ln);
      if (spares) begin
         write_csr(CSR_SPARE_6, 11'h7ff);
         write_csr(CSR_SPARE_7, 11'h7ff);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits until every queued step has been transferred and every result checked.
   task automatic drain();
      while (pending_steps.size() > 0 || req_valid || expected_status.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register settings per random phase: the extremes, fast frames and wide random values.
   task automatic configure_phase(input int p);
      case (p)
         0: program_all(8'd255, 4'hf, 10'd1023, 10'd1023, 10'd1023, 11'd2047, 1'b0);
         4: program_all(8'd0, 4'h0, 10'd1, 10'd1, 10'd1, 11'd1, 1'b0);
         3, 6: program_all(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                           10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
                           10'($urandom_range(1, 1023)), 11'($urandom_range(1, 2047)), 1'b0);
         default: program_all(8'($urandom_range(0, 159)), 4'($urandom_range(0, 15)),
                              10'($urandom_range(1, 40)), 10'($urandom_range(1, 40)),
                              10'($urandom_range(1, 40)), 11'($urandom_range(1, 60)), 1'b0);
      endcase
   endtask

   // Stimulus sequence.
   initial begin
      reset_timing_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed steps with the reset register values, display off included.
      queue_step(8'd0, 1'b1);
      queue_step(8'd255, 1'b1);
      queue_step(8'd80, 1'b1);
      queue_step(8'd172, 1'b1);
      queue_step(8'd204, 1'b1);
      queue_step(8'd255, 1'b1);
      queue_step(8'd0, 1'b0);
      queue_step(8'd255, 1'b0);
      queue_step(8'd1, 1'b1);
      queue_step(8'd128, 1'b1);
      drain();

      // Zero durations end each phase at once; the unused indexes must change nothing.
      program_all(8'd1, 4'hf, 10'd0, 10'd0, 10'd0, 11'd0, 1'b1);
      for (int i = 0; i < 12; i++) begin
         queue_step((i % 3 == 0) ? 8'd255 : 8'(i % 2), 1'b1);
      end
      drain();

      // Random phases, mostly with the display on so the frame runs through vblank.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         configure_phase(p);
         if (p == RANDOM_PHASES - 1) quiet = 1'b1;
         for (int i = 0; i < STEPS_PER_PHASE; i++) begin
            queue_step(pick_elapsed(), ($urandom_range(0, 59) != 0));
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #10000000;
      $display("Verification failed");
      $finish;
   end

endmodule
